// ===== hw/rtl/sip_style_string_hash_id_unit_assert.svh =====
// Assertion helpers for the hash id unit. Both expect clk and rst in scope.
`ifndef SIP_STYLE_STRING_HASH_ID_UNIT_ASSERT_SVH
`define SIP_STYLE_STRING_HASH_ID_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sship_pkg.sv =====
`timescale 1ns / 1ps

package sship_pkg;

  localparam int CHAR_BITS = 16;
  localparam int ID_BITS   = 32;

  localparam logic [63:0] SEED_ZERO  = 64'h736f6d6570736575;
  localparam logic [63:0] SEED_ONE   = 64'h646f72616e646f6d;
  localparam logic [63:0] SEED_TWO   = 64'h6c7967656e657261;
  localparam logic [63:0] SEED_THREE = 64'h7465646279746573;

  localparam logic [ID_BITS-1:0] ID_OFFSET = 32'd100;
  localparam logic [ID_BITS-1:0] FOLD_ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  localparam lanes_t SEED_LANES = '{v0: SEED_ZERO, v1: SEED_ONE,
                                    v2: SEED_TWO, v3: SEED_THREE};

  function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  // One SipRound: two dependent 64-bit adds on the longest path.
  function automatic lanes_t lane_round(input lanes_t s);
    lanes_t r;
    r = s;
    r.v0 = r.v0 + r.v1;
    r.v1 = rotl(r.v1, 13) ^ r.v0;
    r.v0 = rotl(r.v0, 32);
    r.v2 = r.v2 + r.v3;
    r.v3 = rotl(r.v3, 16) ^ r.v2;
    r.v0 = r.v0 + r.v3;
    r.v3 = rotl(r.v3, 21) ^ r.v0;
    r.v2 = r.v2 + r.v1;
    r.v1 = rotl(r.v1, 17) ^ r.v2;
    r.v2 = rotl(r.v2, 32);
    return r;
  endfunction

endpackage

// ===== hw/rtl/sship_absorb.sv =====
`timescale 1ns / 1ps

// Character absorb: running lane state plus the hand-off register to finalization.
module sship_absorb (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [sship_pkg::CHAR_BITS-1:0] character,
  input  logic                           is_last,
  input  logic                           advance,
  output logic                           fin_valid,
  output sship_pkg::lanes_t              fin_lanes
);

  sship_pkg::lanes_t lanes;
  sship_pkg::lanes_t mixed;
  sship_pkg::lanes_t pre;
  logic [63:0]       ch64;

  always_comb begin
    ch64     = 64'(character);
    pre      = lanes;
    pre.v3   = lanes.v3 ^ ch64;
    mixed    = sship_pkg::lane_round(pre);
    mixed.v0 = mixed.v0 ^ ch64;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes     <= sship_pkg::SEED_LANES;
      fin_valid <= 1'b0;
    end else begin
      if (accept) begin
        lanes <= is_last ? sship_pkg::SEED_LANES : mixed;
      end
      if (advance) begin
        fin_valid <= accept && is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept && is_last) begin
      fin_lanes <= mixed;
    end
  end

endmodule

// ===== hw/rtl/sship_round_stage.sv =====
`timescale 1ns / 1ps

// One finalization round, registered.
module sship_round_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  sship_pkg::lanes_t in_lanes,
  output logic              out_valid,
  output sship_pkg::lanes_t out_lanes
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_lanes <= sship_pkg::lane_round(in_lanes);
    end
  end

endmodule

// ===== hw/rtl/sship_fold_stage.sv =====
`timescale 1ns / 1ps

// Lane fold, mod 2^32-1 and offset; its register is the result register.
module sship_fold_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  sship_pkg::lanes_t             in_lanes,
  output logic                          out_valid,
  output logic [sship_pkg::ID_BITS-1:0] type_id
);

  logic [63:0]                   fold64;
  logic [sship_pkg::ID_BITS-1:0] fold32;
  logic [sship_pkg::ID_BITS-1:0] reduced;

  always_comb begin
    fold64  = in_lanes.v0 ^ in_lanes.v1 ^ in_lanes.v2 ^ in_lanes.v3;
    fold32  = fold64[31:0] ^ fold64[63:32];
    // all-ones is the only fold value that reaches the modulus
    reduced = (fold32 == sship_pkg::FOLD_ALL_ONES) ? '0 : fold32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      type_id <= reduced + sship_pkg::ID_OFFSET;
    end
  end

endmodule

// ===== hw/rtl/sip_style_string_hash_id_unit.sv =====
`timescale 1ns / 1ps
// A last character accepted on the input shows its type id on m_tvalid after passing
//   the absorb hand-off, four round stages and the fold. Other characters give nothing.
// Throughput: one character per cycle while s_tready is high; the single-round lane feedback sets it.
// Reset (rst, synchronous, active high): lanes reload the seed words, all stage
//   valids and the result valid clear.

module sip_style_string_hash_id_unit (
  input  logic        clk,
  input  logic        rst,
  // request in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] character
  input  logic        s_tlast,   // is_last
  // result out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] type_id
);

  localparam int NUM_ROUNDS = 4;

  // Stage 0 is the absorb hand-off, 1..4 the finalization rounds.
  logic [NUM_ROUNDS:0]   p_valid;
  sship_pkg::lanes_t     p_lanes [NUM_ROUNDS+1];
  // Per-stage enable; index NUM_ROUNDS+1 is the result register.
  logic [NUM_ROUNDS+1:0] stage_en;
  logic                  s_accept;

  // A stage moves when it is empty or the stage after it moves, so bubbles
  // collapse and a waiting result stops absorbing only once every stage is full.
  assign stage_en[NUM_ROUNDS+1] = !m_tvalid || m_tready;

  genvar k;
  generate
    for (k = 0; k <= NUM_ROUNDS; k++) begin : g_en
      assign stage_en[k] = !p_valid[k] || stage_en[k+1];
    end
  endgenerate

  assign s_tready = stage_en[0];
  assign s_accept = s_tvalid && s_tready;

  sship_absorb u_absorb (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .character (s_tdata[sship_pkg::CHAR_BITS-1:0]),
    .is_last   (s_tlast),
    .advance   (stage_en[0]),
    .fin_valid (p_valid[0]),
    .fin_lanes (p_lanes[0])
  );

  generate
    for (k = 1; k <= NUM_ROUNDS; k++) begin : g_round
      sship_round_stage u_round (
        .clk       (clk),
        .rst       (rst),
        .advance   (stage_en[k]),
        .in_valid  (p_valid[k-1]),
        .in_lanes  (p_lanes[k-1]),
        .out_valid (p_valid[k]),
        .out_lanes (p_lanes[k])
      );
    end
  endgenerate

  sship_fold_stage u_fold (
    .clk       (clk),
    .rst       (rst),
    .advance   (stage_en[NUM_ROUNDS+1]),
    .in_valid  (p_valid[NUM_ROUNDS]),
    .in_lanes  (p_lanes[NUM_ROUNDS]),
    .out_valid (m_tvalid),
    .type_id   (m_tdata)
  );

  `include "sip_style_string_hash_id_unit_assert.svh"

  // A character without the last mark never starts a finalization.
  `SSH_ASSERT_NEXT(a_no_fin_on_mid, s_accept && !s_tlast, !p_valid[0], "mid char started fin")
  // A new result only comes from the last round stage.
  `SSH_ASSERT_NOW(a_result_src, $rose(m_tvalid), $past(p_valid[NUM_ROUNDS]), "stray result")

endmodule

// ===== test/tb_sip_style_string_hash_id_unit.sv =====
`timescale 1ns / 1ps

module tb_sip_style_string_hash_id_unit;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 12;
  localparam int HOLD_OFF_CYCLES = 300;   // long output stall, block must back up
  localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no request or result moving
  localparam int SETTLE_CYCLES   = 20;    // margin for the pipeline to drain
  localparam int MAX_REPORTS     = 10;

  // Seed words of the four lanes.
  localparam logic [63:0] LANE0_SEED = 64'h736f6d6570736575;
  localparam logic [63:0] LANE1_SEED = 64'h646f72616e646f6d;
  localparam logic [63:0] LANE2_SEED = 64'h6c7967656e657261;
  localparam logic [63:0] LANE3_SEED = 64'h7465646279746573;
  localparam logic [31:0] TYPE_ID_OFFSET = 32'd100;
  localparam logic [31:0] FOLD_WRAP      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [63:0] l0;
    logic [63:0] l1;
    logic [63:0] l2;
    logic [63:0] l3;
  } hash_lanes_t;

  localparam hash_lanes_t LANE_SEEDS = '{l0: LANE0_SEED, l1: LANE1_SEED,
                                         l2: LANE2_SEED, l3: LANE3_SEED};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] character
  logic        s_tlast = 1'b0; // is_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] type_id

  sip_style_string_hash_id_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hash state of the name in progress and type ids still owed by the block.
  hash_lanes_t   name_lanes = LANE_SEEDS;
  logic [31:0]   pending_ids[$];
  int            fail_count   = 0;
  int            chars_sent   = 0;
  bit            tx_idling    = 1'b0;
  bit            rx_idling    = 1'b0;
  bit            hold_off_req = 1'b0;
  int            rx_stall_left = 0;
  int            quiet_cycles  = 0;

  function automatic logic [63:0] rol64(input logic [63:0] x, input int k);
    logic [127:0] twice;
    twice = {x, x};
    return twice[127 - k -: 64];
  endfunction

  function automatic hash_lanes_t sip_mix(input hash_lanes_t s);
    hash_lanes_t t;
    t = s;
    t.l0 = t.l0 + t.l1;
    t.l1 = rol64(t.l1, 13) ^ t.l0;
    t.l0 = rol64(t.l0, 32);
    t.l2 = t.l2 + t.l3;
    t.l3 = rol64(t.l3, 16) ^ t.l2;
    t.l0 = t.l0 + t.l3;
    t.l3 = rol64(t.l3, 21) ^ t.l0;
    t.l2 = t.l2 + t.l1;
    t.l1 = rol64(t.l1, 17) ^ t.l2;
    t.l2 = rol64(t.l2, 32);
    return t;
  endfunction

  // Absorb one accepted character; on the last one finalize and queue the id.
  task automatic hash_absorb(input logic [15:0] ch, input logic last);
    logic [63:0] wide;
    logic [63:0] fold64;
    logic [31:0] fold32;
    logic [31:0] id;
    wide = {48'd0, ch};
    name_lanes.l3 = name_lanes.l3 ^ wide;
    name_lanes = sip_mix(name_lanes);
    name_lanes.l0 = name_lanes.l0 ^ wide;
    if (last) begin
      repeat (4) name_lanes = sip_mix(name_lanes);
      fold64 = name_lanes.l0 ^ name_lanes.l1 ^ name_lanes.l2 ^ name_lanes.l3;
      fold32 = fold64[63:32] ^ fold64[31:0];
      // mod 2^32-1 only moves the all-ones fold; the offset add wraps
      id = (fold32 == FOLD_WRAP) ? 32'd0 : fold32;
      id = id + TYPE_ID_OFFSET;
      pending_ids.push_back(id);
      name_lanes = LANE_SEEDS;
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Result checker: every accepted type id against the oldest one owed.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_ids.size() == 0) begin
        note_failure($sformatf("type id %08h with no request pending", m_tdata));
      end else begin
        want = pending_ids.pop_front();
        if (m_tdata !== want)
          note_failure($sformatf("type_id expected %08h actual %08h", want, m_tdata));
      end
    end
  end

  // Watchdog: ends the run when neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[%0t] ERROR: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, mostly short, a few long; plus the long hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (rx_stall_left > 0) begin
        m_tready <= 1'b0;
        rx_stall_left--;
      end else if (rx_idling && $urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) - 1
                                                     : $urandom_range(1, 3) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one character, with an optional gap first; returns once accepted.
  task automatic send_char(input logic [15:0] ch, input logic last);
    int gap;
    gap = 0;
    if (tx_idling && $urandom_range(0, 99) < 30)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    hash_absorb(ch, last);
    chars_sent++;
  endtask

  function automatic logic [15:0] pick_char();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) return 16'($urandom_range(32, 126));          // printable ASCII
    if (kind < 70) return 16'($urandom_range(0, 16'hFFFF));      // any code
    if (kind < 85) return 16'($urandom_range(16'h4E00, 16'h9FFF)); // CJK block
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'h0001;
    endcase
  endfunction

  task automatic send_name(input int len);
    for (int i = 0; i < len; i++) send_char(pick_char(), i == len - 1);
  endtask

  function automatic int pick_name_len();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) return $urandom_range(1, 4);
    if (kind < 90) return $urandom_range(5, 16);
    return $urandom_range(17, 64);
  endfunction

  // Sender goes quiet until the block has delivered every owed type id.
  task automatic pause_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_ids.size() != 0) @(posedge clk);
  endtask

  // Field extremes, single and multi character names, back to back last marks.
  task automatic test_directed_names();
    logic [15:0] word[9];
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    send_char(16'h0041, 1'b1);
    send_char(16'h0000, 1'b1);
    send_char(16'hFFFF, 1'b1);
    send_char(16'h8000, 1'b1);
    send_char(16'h0001, 1'b1);
    send_char(16'h0069, 1'b0);
    send_char(16'h0064, 1'b1);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0000, 1'b0);
    send_char(16'hFFFF, 1'b1);
    send_char(16'hAAAA, 1'b0);
    send_char(16'h5555, 1'b1);
    word = '{16'h54, 16'h72, 16'h61, 16'h6E, 16'h73, 16'h66, 16'h6F, 16'h72, 16'h6D};
    for (int i = 0; i < 9; i++) send_char(word[i], i == 8);
    pause_until_drained();
  endtask

  // One-character names: a result per request, under idling on both sides.
  task automatic test_single_char_names();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    repeat (150) send_char(pick_char(), 1'b1);
  endtask

  // Output held off while short names keep coming: the pipe fills and s_tready drops.
  task automatic test_output_hold_off();
    pause_until_drained();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    hold_off_req = 1'b1;
    repeat (50) send_name($urandom_range(1, 2));
    pause_until_drained();
  endtask

  // Bulk of the run: random names, idling switched per segment.
  task automatic test_random_names();
    int target;
    target = chars_sent + 1350;
    while (chars_sent < target) begin
      tx_idling = ($urandom_range(0, 2) != 0);
      rx_idling = ($urandom_range(0, 2) != 0);
      repeat (20) send_name(pick_name_len());
    end
  endtask

  // Names separated by full drains, so each starts on an empty pipeline.
  task automatic test_sender_pause();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    repeat (12) begin
      send_name(pick_name_len());
      pause_until_drained();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_names();
    test_single_char_names();
    test_output_hold_off();
    test_random_names();
    test_sender_pause();

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_ids.size() != 0)
      note_failure($sformatf("%0d type ids never arrived", pending_ids.size()));

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sship_pkg.sv
hw/rtl/sship_absorb.sv
hw/rtl/sship_round_stage.sv
hw/rtl/sship_fold_stage.sv
hw/rtl/sip_style_string_hash_id_unit.sv
test/tb_sip_style_string_hash_id_unit.sv
